### rtl/lba_pkg.sv
// Shared types, constants and helper functions for the label bitmap allocator.
`default_nettype none

package lba_pkg;

   // Bitmap geometry.
   localparam int NUM_BUCKETS     = 1024;
   localparam int BITS_PER_BUCKET = 8;
   localparam int NUM_LABELS      = NUM_BUCKETS * BITS_PER_BUCKET;
   localparam int BKT_AW          = $clog2(NUM_BUCKETS);
   localparam int BIT_AW          = $clog2(BITS_PER_BUCKET);
   localparam int OFS_W           = BKT_AW + BIT_AW;

   // Field widths.
   localparam int LABEL_W = 20;
   localparam int COUNT_W = 14;

   localparam logic [LABEL_W-1:0] RESERVED_TOP = LABEL_W'(16);
   localparam logic [LABEL_W-1:0] BASE_RESET   = LABEL_W'(17);
   localparam logic [COUNT_W-1:0] COUNT_RESET  = COUNT_W'(NUM_LABELS);
   localparam logic [BKT_AW-1:0]  LAST_BKT     = BKT_AW'(NUM_BUCKETS - 1);
   localparam logic [BITS_PER_BUCKET-1:0] BKT_FULL = '1;

   // Operation codes carried on the request channel.
   typedef enum logic {
      MODE_ALLOC = 1'b0,
      MODE_FREE  = 1'b1
   } lba_mode_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_RANGE = 2'd2,
      STAT_FREE  = 2'd3
   } lba_status_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ISSUE,
      ST_EVAL,
      ST_DONE
   } lba_state_type;

   // Bitmap memory access request from the controller.
   typedef struct packed {
      logic                       rd_en;
      logic [BKT_AW-1:0]          rd_addr;
      logic                       wr_en;
      logic [BKT_AW-1:0]          wr_addr;
      logic [BITS_PER_BUCKET-1:0] wr_data;
   } lba_mem_req_type;

   // One finished result.
   typedef struct packed {
      logic [LABEL_W-1:0] label_out;
      lba_status_type     status;
      logic [COUNT_W-1:0] free_count;
   } lba_result_type;

   // Index of the lowest clear bit of a bucket (top bit if all set).
   function automatic logic [BIT_AW-1:0] lowest_clear(input logic [BITS_PER_BUCKET-1:0] v);
      logic [BIT_AW-1:0] idx;
      idx = BIT_AW'(BITS_PER_BUCKET - 1);
      for (int i = BITS_PER_BUCKET - 1; i >= 0; i--) begin
         if (!v[i]) begin
            idx = BIT_AW'(i);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

### rtl/lba_bitmap_ram.sv
// Single-port-write, single-port-read bitmap memory with a registered read.
`default_nettype none

module lba_bitmap_ram (
   input  wire logic                                clock,
   input  wire lba_pkg::lba_mem_req_type            mem_req,
   output logic [lba_pkg::BITS_PER_BUCKET-1:0]      rd_data
);
   import lba_pkg::*;

   logic [BITS_PER_BUCKET-1:0] mem [NUM_BUCKETS];
   logic [BITS_PER_BUCKET-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/lba_ctrl.sv
// Sequencer: clears the bitmap, scans for free labels, and handles frees.
`default_nettype none

module lba_ctrl (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire lba_pkg::lba_mode_type               req_mode,
   input  wire logic [lba_pkg::LABEL_W-1:0]         req_label,
   input  wire logic [lba_pkg::LABEL_W-1:0]         label_base,
   output lba_pkg::lba_mem_req_type                 mem_req,
   input  wire logic [lba_pkg::BITS_PER_BUCKET-1:0] rd_data,
   output logic                                     res_valid,
   input  wire logic                                res_ready,
   output lba_pkg::lba_result_type                  result
);
   import lba_pkg::*;

   lba_state_type             state_ff, state_in;
   logic [BKT_AW-1:0]         clr_addr_ff, clr_addr_in;
   lba_mode_type              mode_ff, mode_in;
   logic [LABEL_W-1:0]        label_ff, label_in;
   logic [BKT_AW-1:0]         bucket_ff, bucket_in;
   logic [BIT_AW-1:0]         bit_ff, bit_in;
   logic [BKT_AW-1:0]         scan_cnt_ff, scan_cnt_in;
   logic [BKT_AW-1:0]         scan_start_ff, scan_start_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [LABEL_W-1:0]        res_label_ff, res_label_in;
   lba_status_type            res_status_ff, res_status_in;

   logic [LABEL_W-1:0]        offset;
   logic                      range_bad;
   logic                      bkt_full;
   logic                      scan_last;
   logic [BIT_AW-1:0]         clear_idx;
   logic                      bit_set;

   // Offset of a freed label within the managed range, modulo 2^20.
   assign offset    = label_ff - label_base - LABEL_W'(1);
   assign range_bad = (label_ff <= RESERVED_TOP) || (offset[LABEL_W-1:OFS_W] != '0);
   assign bkt_full  = (rd_data == BKT_FULL);
   assign scan_last = (scan_cnt_ff == LAST_BKT);
   assign clear_idx = lowest_clear(rd_data);
   assign bit_set   = rd_data[bit_ff];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == LAST_BKT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (mode_ff == MODE_ALLOC) begin
               state_in = (count_ff == '0) ? ST_DONE : ST_EVAL;
            end else begin
               state_in = range_bad ? ST_DONE : ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (mode_ff == MODE_ALLOC && bkt_full && !scan_last) begin
               state_in = ST_EVAL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Outputs: handshakes and memory accesses.
   always_comb begin
      req_ready       = 1'b0;
      res_valid       = 1'b0;
      mem_req.rd_en   = 1'b0;
      mem_req.rd_addr = bucket_ff;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = bucket_ff;
      mem_req.wr_data = rd_data;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = clr_addr_ff;
            mem_req.wr_data = '0;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_ISSUE: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = (mode_ff == MODE_ALLOC) ? scan_start_ff
                                                      : offset[OFS_W-1:BIT_AW];
         end
         ST_EVAL: begin
            if (mode_ff == MODE_ALLOC) begin
               if (!bkt_full) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_data = rd_data | (BITS_PER_BUCKET'(1) << clear_idx);
               end else if (!scan_last) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = bucket_ff + BKT_AW'(1);
               end
            end else if (bit_set) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_data = rd_data & ~(BITS_PER_BUCKET'(1) << bit_ff);
            end
         end
         ST_DONE: begin
            res_valid = 1'b1;
         end
         default: ;
      endcase
   end

   // Datapath next values.
   always_comb begin
      clr_addr_in   = clr_addr_ff;
      mode_in       = mode_ff;
      label_in      = label_ff;
      bucket_in     = bucket_ff;
      bit_in        = bit_ff;
      scan_cnt_in   = scan_cnt_ff;
      scan_start_in = scan_start_ff;
      count_in      = count_ff;
      res_label_in  = res_label_ff;
      res_status_in = res_status_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + BKT_AW'(1);
         end
         ST_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               label_in = req_label;
            end
         end
         ST_ISSUE: begin
            res_label_in = '0;
            scan_cnt_in  = '0;
            if (mode_ff == MODE_ALLOC) begin
               bucket_in     = scan_start_ff;
               res_status_in = STAT_FULL;
            end else begin
               bucket_in     = offset[OFS_W-1:BIT_AW];
               bit_in        = offset[BIT_AW-1:0];
               res_status_in = STAT_RANGE;
            end
         end
         ST_EVAL: begin
            if (mode_ff == MODE_ALLOC) begin
               if (!bkt_full) begin
                  count_in      = count_ff - COUNT_W'(1);
                  scan_start_in = scan_start_ff + BKT_AW'(1);
                  res_status_in = STAT_OK;
                  res_label_in  = label_base + LABEL_W'({bucket_ff, clear_idx})
                                  + LABEL_W'(1);
               end else begin
                  bucket_in     = bucket_ff + BKT_AW'(1);
                  scan_cnt_in   = scan_cnt_ff + BKT_AW'(1);
                  res_status_in = STAT_FULL;
               end
            end else if (bit_set) begin
               count_in      = count_ff + COUNT_W'(1);
               res_status_in = STAT_OK;
            end else begin
               res_status_in = STAT_FREE;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         scan_start_ff <= '0;
         count_ff      <= COUNT_RESET;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         scan_start_ff <= scan_start_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      label_ff      <= label_in;
      bucket_ff     <= bucket_in;
      bit_ff        <= bit_in;
      scan_cnt_ff   <= scan_cnt_in;
      res_label_ff  <= res_label_in;
      res_status_ff <= res_status_in;
   end

   assign result.label_out  = res_label_ff;
   assign result.status     = res_status_ff;
   assign result.free_count = count_ff;

   // The free count can never exceed the number of managed labels.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_RESET)
      else $error("free count above label total");

   // Only one memory access per cycle: reads and writes never overlap.
   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_req.rd_en && mem_req.wr_en))
      else $error("read and write in the same cycle");

   // No bitmap update while waiting for a request or a result slot.
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_DONE) |-> !mem_req.wr_en)
      else $error("bitmap written outside an operation");

   // A successful allocation consumes exactly one free label.
   a_alloc_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL && mode_ff == MODE_ALLOC && !bkt_full)
      |=> (count_ff == $past(count_ff) - COUNT_W'(1)))
      else $error("allocation did not decrement free count");

   // An accepted request always moves on to the read issue step.
   a_accept_issue: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_ISSUE))
      else $error("accepted request not issued");

endmodule

`default_nettype wire

### rtl/label_bitmap_allocator_core.sv
// Top level of the label bitmap allocator: stream ports, CSR and result register.
`default_nettype none

//  Channel | Direction | Payload
//  --------+-----------+------------------------------------------------------
//  req_    | in        | tuser[0] mode; tdata[19:0] label
//  rsp_    | out       | tuser[1:0] status; tdata[19:0] label_out,
//          |           | tdata[33:20] free_count
//  csr_    | in        | data[19:0] label_base
//
//  A free, or an allocation that hits its bucket first, passes the issue and
//  evaluate states, then waits in the done state until the word moves into the
//  result register; a full or range-rejected word skips the evaluate state. The
//  next request word is taken once the controller is back in idle. Each fully
//  occupied bucket the allocation scan passes adds one more evaluate step, since
//  the scan reads one bucket per cycle from the single read port of the bitmap.
//  After reset the bitmap is cleared, one bucket per cycle, across all 1024
//  buckets; req_tready stays low during that pass while CSR writes are still
//  taken. The result register lets the next request word be accepted while a
//  finished result waits on rsp_tready.

module label_bitmap_allocator_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // [19:0] label, [23:20] zero
   input  wire logic [0:0]  req_tuser,  // [0] mode
   // Result channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,  // [19:0] label_out, [33:20] free_count, [39:34] zero
   output logic [1:0]       rsp_tuser,  // [1:0] status
   // Configuration write channel.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [lba_pkg::LABEL_W-1:0] csr_data
);
   import lba_pkg::*;

   logic [LABEL_W-1:0] label_base_ff, label_base_in;
   lba_mem_req_type    mem_req;
   logic [BITS_PER_BUCKET-1:0] rd_data;
   logic               res_valid;
   logic               res_ready;
   lba_result_type     result;
   logic               rsp_valid_ff, rsp_valid_in;
   lba_result_type     rsp_word_ff, rsp_word_in;
   lba_mode_type       req_mode;

   // The base register is always ready; writes must only happen while idle, which the block itself does not enforce.
   assign csr_ready     = 1'b1;
   assign label_base_in = (csr_valid && csr_ready) ? csr_data : label_base_ff;

   assign req_mode = lba_mode_type'(req_tuser[0]);

   lba_bitmap_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   lba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_mode   (req_mode),
      .req_label  (req_tdata[LABEL_W-1:0]),
      .label_base (label_base_ff),
      .mem_req    (mem_req),
      .rd_data    (rd_data),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .result     (result)
   );

   // The result register takes a new word when empty or being drained.
   assign res_ready    = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = (res_valid && res_ready) || (rsp_valid_ff && !rsp_tready);
   assign rsp_word_in  = (res_valid && res_ready) ? result : rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         label_base_ff <= BASE_RESET;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         label_base_ff <= label_base_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_word_ff.free_count, rsp_word_ff.label_out};
   assign rsp_tuser  = rsp_word_ff.status;

endmodule

`default_nettype wire

### verif/label_alloc_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the label bitmap allocator: mirrors the bitmap and checks each result word.

module label_alloc_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   input  wire logic                        req_tready,
   input  wire logic [23:0]                 req_tdata,  // [19:0] label, [23:20] zero
   input  wire logic [0:0]                  req_tuser,  // [0] mode
   input  wire logic                        rsp_tvalid,
   input  wire logic                        rsp_tready,
   input  wire logic [39:0]                 rsp_tdata,  // [19:0] label_out, [33:20] free_count
   input  wire logic [1:0]                  rsp_tuser,  // [1:0] status
   input  wire logic                        csr_valid,
   input  wire logic                        csr_ready,
   input  wire logic [lba_pkg::LABEL_W-1:0] csr_data,
   output int                               mismatch_count,
   output int                               outstanding,
   output int                               words_checked,
   output int                               full_hits
);

   import lba_pkg::*;

   localparam int COUNT_SAT = (1 << COUNT_W) - 1;

   logic [BITS_PER_BUCKET-1:0] bucket_map [NUM_BUCKETS];
   logic [BKT_AW-1:0]          scan_ptr;
   int unsigned                free_total;
   logic [LABEL_W-1:0]         base_reg;
   lba_result_type             pending_results [$];
   int                         fails;
   int                         checked;
   int                         fulls;

   // Applies one request word to the mirrored bitmap and returns the result it should produce.
   task automatic apply_label_op(input lba_mode_type op, input logic [LABEL_W-1:0] lbl,
                                 output lba_result_type res);
      logic [BKT_AW-1:0]  b;
      logic [BIT_AW-1:0]  pos;
      logic [LABEL_W-1:0] ofs;
      int                 n;
      res.label_out = '0;
      res.status    = STAT_OK;
      if (op == MODE_ALLOC) begin
         if (free_total == 0) begin
            res.status = STAT_FULL;
         end else begin
            b = scan_ptr;
            n = 0;
            while (n < NUM_BUCKETS && bucket_map[b] == BKT_FULL) begin
               b = (b == LAST_BKT) ? '0 : b + 1'b1;
               n++;
            end
            if (n == NUM_BUCKETS) begin
               res.status = STAT_FULL;
            end else begin
               pos = '0;
               while (pos < BIT_AW'(BITS_PER_BUCKET - 1) && bucket_map[b][pos]) pos++;
               bucket_map[b][pos] = 1'b1;
               free_total--;
               // The pointer moves on from where the scan began, not from the bucket found.
               scan_ptr = (scan_ptr == LAST_BKT) ? '0 : scan_ptr + 1'b1;
               res.label_out = base_reg + LABEL_W'({b, pos}) + 1'b1;
            end
         end
      end else begin
         ofs = lbl - base_reg - 1'b1;
         if (lbl <= RESERVED_TOP || ofs >= LABEL_W'(NUM_LABELS)) begin
            res.status = STAT_RANGE;
         end else begin
            b   = ofs[OFS_W-1:BIT_AW];
            pos = ofs[BIT_AW-1:0];
            if (!bucket_map[b][pos]) begin
               res.status = STAT_FREE;
            end else begin
               bucket_map[b][pos] = 1'b0;
               free_total++;
            end
         end
      end
      res.free_count = (free_total > COUNT_SAT) ? COUNT_W'(COUNT_SAT) : COUNT_W'(free_total);
   endtask

   task automatic report(input string what, input lba_result_type want,
                         input lba_result_type got);
      fails++;
      if (fails <= 10) begin
         $display("[%0t] %s: expected label %0d status %0d count %0d, got label %0d status %0d count %0d",
                  $time, what, want.label_out, want.status, want.free_count,
                  got.label_out, got.status, got.free_count);
      end
   endtask

   always @(posedge clock) begin : watch
      lba_result_type want;
      lba_result_type got;
      if (reset) begin
         foreach (bucket_map[i]) bucket_map[i] = '0;
         scan_ptr   = '0;
         free_total = NUM_LABELS;
         base_reg   = BASE_RESET;
         pending_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.label_out  = rsp_tdata[LABEL_W-1:0];
            got.status     = lba_status_type'(rsp_tuser);
            got.free_count = rsp_tdata[LABEL_W +: COUNT_W];
            checked++;
            if (pending_results.size() == 0) begin
               want = '0;
               report("unexpected result word", want, got);
            end else begin
               want = pending_results.pop_front();
               if (want.status == STAT_FULL) fulls++;
               if (got.label_out !== want.label_out || got.status !== want.status ||
                   got.free_count !== want.free_count) begin
                  report("result mismatch", want, got);
               end
            end
         end
         if (csr_valid && csr_ready) base_reg = csr_data;
         if (req_tvalid && req_tready) begin
            apply_label_op(lba_mode_type'(req_tuser[0]), req_tdata[LABEL_W-1:0], want);
            pending_results.push_back(want);
         end
      end
      mismatch_count <= fails;
      outstanding    <= pending_results.size();
      words_checked  <= checked;
      full_hits      <= fulls;
   end

endmodule

### verif/tb_label_bitmap_allocator_core.sv
`timescale 1ns / 1ps
// Testbench top for the label bitmap allocator: stimulus, handshake pacing and verdict.

module tb_label_bitmap_allocator_core;

   import lba_pkg::*;

   // Generous bound: the clearing pass and about eighteen hundred words with the largest
   // idle gaps on each side stay far below it, even if every scan ran over the whole bitmap.
   localparam int CYCLE_LIMIT = 3_000_000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [23:0]         req_tdata = '0;   // [19:0] label, [23:20] zero
   logic [0:0]          req_tuser = '0;   // [0] mode
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [39:0]         rsp_tdata;        // [19:0] label_out, [33:20] free_count, [39:34] zero
   logic [1:0]          rsp_tuser;        // [1:0] status
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [LABEL_W-1:0]  csr_data = '0;

   int mismatch_count;
   int outstanding;
   int words_checked;
   int full_hits;
   int cycle_count = 0;
   int words_sent = 0;
   int base_writes = 0;
   int req_quiet = 0;
   int rsp_quiet = 0;

   // Labels the block has handed out and that the stimulus has not freed yet, plus a short
   // history of freed labels used to provoke double frees.
   logic [LABEL_W-1:0] live_labels [$];
   logic [LABEL_W-1:0] recent [$];
   logic [LABEL_W-1:0] cur_base = BASE_RESET;
   logic               pool_live = 1'b0;

   label_bitmap_allocator_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   label_alloc_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .words_checked  (words_checked),
      .full_hits      (full_hits)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Watchdog: a hang anywhere (a lost result word, a stuck handshake) ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d result words outstanding.",
                  cycle_count, outstanding);
         $display("tb_label_bitmap_allocator_core NOT OK");
         $finish;
      end
   end

   // Idle cycles before the next word on one side. Now and then a stretch of back-to-back
   // words follows, so the block also sees full-rate traffic.
   function automatic int draw_idle(inout int quiet);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 31) == 0) quiet = $urandom_range(8, 48);
      return $urandom_range(0, 10);
   endfunction

   // Result side pacing. The ready line is only ever given one new value per clock edge:
   // with no stall drawn it simply stays high for the next word.
   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_idle(rsp_quiet);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
      end
   end

   // Collects labels that allocations returned. It samples at the falling edge, where the
   // handshake that completes at the next rising edge is already settled, so it never races
   // the stimulus process that picks labels at the rising edge. A free always answers with
   // label 0, so a nonzero OK word is an allocation.
   always @(negedge clock) begin
      if (pool_live && rsp_tvalid && rsp_tready && rsp_tuser == STAT_OK &&
          rsp_tdata[LABEL_W-1:0] != '0) begin
         live_labels.push_back(rsp_tdata[LABEL_W-1:0]);
      end
   end

   // Offers one request word after a random gap and returns once it is accepted. The valid
   // line stays high afterwards so that a zero gap gives back-to-back words.
   task automatic send_word(input lba_mode_type op, input logic [LABEL_W-1:0] lbl);
      int gap;
      gap = draw_idle(req_quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, lbl};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
   endtask

   // Stops offering words and waits until every expected result word has come back.
   // Each request yields exactly one result, so nothing can still be in flight after that.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Writes label_base while the block is idle. Tracked labels keep their offsets, so they
   // are moved along with the new base and still name the bits they were allocated from.
   task automatic set_base(input logic [LABEL_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      foreach (live_labels[i]) live_labels[i] = live_labels[i] - cur_base + value;
      cur_base = value;
      base_writes++;
   endtask

   function automatic void drop_label(input logic [LABEL_W-1:0] lbl);
      foreach (live_labels[i]) begin
         if (live_labels[i] == lbl) begin
            live_labels.delete(i);
            return;
         end
      end
   endfunction

   // Frees a randomly chosen label that is known to be allocated.
   task automatic free_tracked();
      int idx;
      logic [LABEL_W-1:0] lbl;
      idx = $urandom_range(0, live_labels.size() - 1);
      lbl = live_labels[idx];
      live_labels.delete(idx);
      recent.push_back(lbl);
      if (recent.size() > 32) void'(recent.pop_front());
      send_word(MODE_FREE, lbl);
   endtask

   // Random traffic: mostly allocations and frees of live labels, the rest bad frees
   // (reserved labels, arbitrary labels, repeats of recent frees, random offsets in the
   // managed range and the labels just outside both ends of it).
   task automatic run_mix(input int count, input int alloc_pct, input int free_pct);
      int pick;
      logic [LABEL_W-1:0] lbl;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < alloc_pct || (pick < alloc_pct + free_pct && live_labels.size() == 0)) begin
            // The label field is ignored on allocation but still gets random bits.
            send_word(MODE_ALLOC, LABEL_W'($urandom));
         end else if (pick < alloc_pct + free_pct) begin
            free_tracked();
         end else begin
            case ($urandom_range(0, 4))
               0: lbl = LABEL_W'($urandom_range(0, 16));
               1: lbl = LABEL_W'($urandom);
               2: lbl = (recent.size() > 0) ? recent[$urandom_range(0, recent.size() - 1)]
                                            : cur_base;
               3: lbl = cur_base + LABEL_W'($urandom_range(1, NUM_LABELS));
               default: begin
                  lbl = $urandom_range(0, 1) ? cur_base : cur_base + LABEL_W'(NUM_LABELS + 1);
               end
            endcase
            drop_label(lbl);
            send_word(MODE_FREE, lbl);
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed words at the reset base of 17. The block is still clearing its bitmap,
      // so the first word waits for the clearing pass to finish.
      send_word(MODE_ALLOC, '0);            // first label of bucket 0: 18
      send_word(MODE_ALLOC, '0);            // the pointer has moved on: bucket 1 gives 26
      send_word(MODE_FREE, 20'd18);
      send_word(MODE_FREE, 20'd18);         // double free
      send_word(MODE_FREE, 20'd0);          // reserved
      send_word(MODE_FREE, 20'd16);         // top of the reserved range
      send_word(MODE_FREE, 20'd17);         // the base itself: offset wraps to the top
      send_word(MODE_FREE, 20'd8209);       // last label in range, never allocated
      send_word(MODE_FREE, 20'd8210);       // first label past the range
      send_word(MODE_FREE, 20'hFFFFF);
      send_word(MODE_FREE, 20'd26);
      send_word(MODE_ALLOC, 20'hFFFFF);     // the label field is ignored on allocation
      send_word(MODE_FREE, 20'd34);
      drain();
      pool_live = 1'b1;

      // Top of the stated base range, then bases where allocated labels wrap past the
      // top of the 20-bit label space or fall into the reserved labels.
      set_base(20'd1040383);
      run_mix(400, 45, 35);
      drain();
      set_base(20'hFFFFF);
      run_mix(300, 45, 35);
      drain();
      set_base('0);
      run_mix(300, 45, 35);
      drain();

      // Release what is tracked under a fresh base, then run a mix that leans toward frees.
      set_base(LABEL_W'($urandom_range(17, 1040383)));
      while (live_labels.size() > 0) free_tracked();
      run_mix(450, 30, 55);
      drain();

      set_base(BASE_RESET);
      run_mix(250, 45, 35);
      drain();
      repeat (16) @(posedge clock);

      $display("Sent %0d request words and checked %0d result words",
               words_sent, words_checked);
      $display("across %0d label_base writes; full answers: %0d; mismatches: %0d.",
               base_writes, full_hits, mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb_label_bitmap_allocator_core OK");
      end else begin
         $display("tb_label_bitmap_allocator_core NOT OK");
      end
      $finish;
   end

endmodule

### label_bitmap_allocator_core.f
rtl/lba_pkg.sv
rtl/lba_bitmap_ram.sv
rtl/lba_ctrl.sv
rtl/label_bitmap_allocator_core.sv
verif/label_alloc_checker.sv
verif/tb_label_bitmap_allocator_core.sv
